[hdl/pdi_instruction_encoder_macros.svh]
// Assertion macros for the PDI instruction encoder.
// Included by modules that carry concurrent checks; needs a clk and rst in scope.
`ifndef PDI_INSTRUCTION_ENCODER_MACROS_SVH
`define PDI_INSTRUCTION_ENCODER_MACROS_SVH

// Check that holds at every clock edge outside reset.
`define PDI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication check: antecedent in this cycle, consequent in the next.
`define PDI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/pdi_enc_pkg.sv]
// Package for the PDI instruction encoder: command codes, opcodes, item types.
// No dependencies.
package pdi_enc_pkg;

  typedef enum logic [3:0] {
    CMD_LDS     = 4'd0,
    CMD_STS     = 4'd1,
    CMD_LD      = 4'd2,
    CMD_ST1     = 4'd3,
    CMD_ST4     = 4'd4,
    CMD_LDCS    = 4'd5,
    CMD_STCS    = 4'd6,
    CMD_REPEAT1 = 4'd7,
    CMD_REPEAT2 = 4'd8,
    CMD_KEY     = 4'd9,
    CMD_RAW     = 4'd10
  } cmd_t;

  localparam logic [7:0] OP_LDS     = 8'h0C;
  localparam logic [7:0] OP_STS     = 8'h4C;
  localparam logic [7:0] OP_LD      = 8'h20;
  localparam logic [7:0] OP_ST1     = 8'h60;
  localparam logic [7:0] OP_ST4     = 8'h63;
  localparam logic [7:0] OP_LDCS    = 8'h80;
  localparam logic [7:0] OP_STCS    = 8'hC0;
  localparam logic [7:0] OP_REPEAT1 = 8'hA0;
  localparam logic [7:0] OP_REPEAT2 = 8'hA1;

  localparam int KEY_LEN  = 9;
  localparam int IDX_W    = 4;
  localparam int S_DATA_W = 88;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] address;
    logic [31:0] data_word;
    logic [1:0]  ptr_mode;
    logic [3:0]  cs_register;
    logic [15:0] repeat_count;
  } item_t;

  typedef struct packed {
    logic       known;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       reply_expected;
  } sel_t;

  // Key sequence, first byte is the KEY opcode.
  function automatic logic [7:0] key_byte(input idx_t i);
    logic [7:0] b;
    case (i)
      4'd0:    b = 8'hE0;
      4'd1:    b = 8'hFF;
      4'd2:    b = 8'h88;
      4'd3:    b = 8'hD8;
      4'd4:    b = 8'hCD;
      4'd5:    b = 8'h45;
      4'd6:    b = 8'hAB;
      4'd7:    b = 8'h89;
      4'd8:    b = 8'h12;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = w[7:0];
      2'd1:    b = w[15:8];
      2'd2:    b = w[23:16];
      default: b = w[31:24];
    endcase
    return b;
  endfunction

endpackage

[hdl/pdi_enc_byte_sel.sv]
// Byte selector: picks the byte at a given position of a command's sequence.
// Depends on pdi_enc_pkg.
module pdi_enc_byte_sel (
  input  pdi_enc_pkg::item_t item,
  input  pdi_enc_pkg::idx_t  idx,
  output pdi_enc_pkg::sel_t  sel
);
  import pdi_enc_pkg::*;

  idx_t       idx_m1;
  idx_t       len;
  logic       reply_cmd;
  logic [7:0] pm;
  logic [7:0] opnd;

  assign idx_m1 = idx - idx_t'(1);
  assign pm     = {4'b0000, item.ptr_mode, 2'b00};

  always_comb begin
    sel.known = 1'b1;
    len       = idx_t'(1);
    reply_cmd = 1'b0;
    opnd      = 8'h00;
    case (item.command)
      CMD_LDS: begin
        len       = idx_t'(5);
        reply_cmd = 1'b1;
        opnd      = (idx == '0) ? OP_LDS : word_byte(item.address, idx_m1[1:0]);
      end
      CMD_STS: begin
        len = idx_t'(6);
        if (idx == '0) begin
          opnd = OP_STS;
        end else if (idx == idx_t'(5)) begin
          opnd = item.data_word[7:0];
        end else begin
          opnd = word_byte(item.address, idx_m1[1:0]);
        end
      end
      CMD_LD: begin
        reply_cmd = 1'b1;
        opnd      = OP_LD | pm;
      end
      CMD_ST1: begin
        len  = idx_t'(2);
        opnd = (idx == '0) ? (OP_ST1 | pm) : item.data_word[7:0];
      end
      CMD_ST4: begin
        len  = idx_t'(5);
        opnd = (idx == '0) ? (OP_ST4 | pm) : word_byte(item.data_word, idx_m1[1:0]);
      end
      CMD_LDCS: begin
        reply_cmd = 1'b1;
        opnd      = OP_LDCS | {4'b0000, item.cs_register};
      end
      CMD_STCS: begin
        len  = idx_t'(2);
        opnd = (idx == '0) ? (OP_STCS | {4'b0000, item.cs_register}) : item.data_word[7:0];
      end
      CMD_REPEAT1: begin
        len  = idx_t'(2);
        opnd = (idx == '0) ? OP_REPEAT1 : item.repeat_count[7:0];
      end
      CMD_REPEAT2: begin
        len = idx_t'(3);
        if (idx == '0) begin
          opnd = OP_REPEAT2;
        end else if (idx == idx_t'(1)) begin
          opnd = item.repeat_count[7:0];
        end else begin
          opnd = item.repeat_count[15:8];
        end
      end
      CMD_KEY: begin
        len  = idx_t'(KEY_LEN);
        opnd = key_byte(idx);
      end
      CMD_RAW: begin
        opnd = item.data_word[7:0];
      end
      default: begin
        sel.known = 1'b0;
      end
    endcase
    sel.tx_byte        = opnd;
    sel.last_byte      = (idx == len - idx_t'(1));
    sel.reply_expected = sel.last_byte & reply_cmd;
  end

endmodule

[hdl/pdi_instruction_encoder.sv]
// PDI instruction encoder top level: command register, byte counter, output register.
// Depends on pdi_enc_pkg, pdi_enc_byte_sel and pdi_instruction_encoder_macros.svh.
//
// Each accepted command is turned into its byte sequence on the master stream, one byte
// per transfer, low byte of multi-byte operands first, with tlast on the final byte and
// tuser set on that byte when the target returns one reply byte (LDS, LD, LDCS). A
// command has 1 to 9 bytes (KEY is longest), walked by the byte counter over the held
// command; the next command is taken in the same cycle as the last byte of the current
// one moves to the output register, so commands stream with no gap. Undefined command
// codes are accepted and dropped with no output. The input transfer loads the command
// register, and the first byte then moves from it into the output register.
module pdi_instruction_encoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // address[31:0], data_word[63:32], ptr_mode[65:64], cs_register[69:66],
  // repeat_count[85:70], zero pad
  input  logic [pdi_enc_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // command[3:0]
  input  logic [3:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tx_byte[7:0]
  output logic [7:0]                           m_axis_tdata,
  output logic                                 m_axis_tlast,
  // reply_expected
  output logic                                 m_axis_tuser
);
  import pdi_enc_pkg::*;

  `include "pdi_instruction_encoder_macros.svh"

  item_t item;
  item_t item_next;
  logic  busy;
  idx_t  idx;
  sel_t  sel;
  logic  out_free;
  logic  out_load;
  logic  item_done;
  logic  s_xfer;

  assign item_next.command      = cmd_t'(s_axis_tuser);
  assign item_next.address      = s_axis_tdata[31:0];
  assign item_next.data_word    = s_axis_tdata[63:32];
  assign item_next.ptr_mode     = s_axis_tdata[65:64];
  assign item_next.cs_register  = s_axis_tdata[69:66];
  assign item_next.repeat_count = s_axis_tdata[85:70];

  pdi_enc_byte_sel u_byte_sel (
    .item (item),
    .idx  (idx),
    .sel  (sel)
  );

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = busy && sel.known && out_free;
  assign item_done     = busy && (!sel.known || (out_free && sel.last_byte));
  assign s_axis_tready = !busy || item_done;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (s_xfer) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (item_done) begin
        busy <= 1'b0;
      end else if (out_load) begin
        idx <= idx + idx_t'(1);
      end
    end
    if (s_xfer) begin
      item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_axis_tdata <= sel.tx_byte;
      m_axis_tlast <= sel.last_byte;
      m_axis_tuser <= sel.reply_expected;
    end
  end

  `PDI_ASSERT(a_reply_on_last, !(m_axis_tvalid && m_axis_tuser && !m_axis_tlast), "reply flag without last")
  `PDI_ASSERT(a_idx_range, !busy || (idx < idx_t'(KEY_LEN)), "byte index out of range")
  `PDI_ASSERT_NEXT(a_hold_on_stall, busy && sel.known && !out_free, busy && $stable(idx), "command lost while output stalled")
  `PDI_ASSERT_NEXT(a_advance, out_load && !sel.last_byte, busy && (idx == $past(idx) + idx_t'(1)), "byte index did not advance")

endmodule

[sim/pdi_instruction_encoder_test.sv]
// Self-checking testbench for pdi_instruction_encoder: command stream in, byte stream out.
// Needs pdi_enc_pkg and the encoder RTL; directed table first, then random commands,
// with each output transfer checked against the table bytes or an encoder model kept here.
`timescale 1ns / 1ps

module pdi_instruction_encoder_test;
  import pdi_enc_pkg::*;

  localparam logic [3:0] CMD_FIRST_UNDEF = 4'd11;
  localparam logic [3:0] CMD_LAST_UNDEF  = 4'd15;
  localparam logic [71:0] UNLOCK_KEY     = 72'h12_89_AB_45_CD_D8_88_FF_E0;
  localparam int UNLOCK_KEY_BYTES = 9;
  localparam int RANDOM_COMMANDS  = 300;
  localparam int STALL_LIMIT      = 1000;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] address;
    logic [31:0] data_word;
    logic [1:0]  ptr_mode;
    logic [3:0]  cs_register;
    logic [15:0] repeat_count;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       reply_expected;
  } link_byte_t;

  // typed rows carry their byte sequence (byte 0 lowest); others go through the model
  typedef struct packed {
    cmd_item_t   item;
    logic        typed;
    logic [3:0]  n_bytes;
    logic [71:0] bytes;
    logic        reply;
  } directed_row_t;

  localparam directed_row_t DIRECTED [24] = '{
    '{'{CMD_LD, 32'h0, 32'h0, 2'd0, 4'd0, 16'h0}, 1'b1, 4'd1, 72'h20, 1'b1},
    '{'{CMD_LD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 4'd15, 16'hFFFF},
      1'b1, 4'd1, 72'h2C, 1'b1},
    '{'{CMD_LDCS, 32'h0, 32'h0, 2'd0, 4'd0, 16'h0}, 1'b1, 4'd1, 72'h80, 1'b1},
    '{'{CMD_LDCS, 32'h0, 32'h0, 2'd3, 4'd15, 16'h0}, 1'b1, 4'd1, 72'h8F, 1'b1},
    '{'{CMD_RAW, 32'h0, 32'hFFFF_FF00, 2'd0, 4'd0, 16'h0}, 1'b1, 4'd1, 72'h00, 1'b0},
    '{'{CMD_RAW, 32'h0, 32'h0000_00FF, 2'd0, 4'd0, 16'h0}, 1'b1, 4'd1, 72'hFF, 1'b0},
    '{'{CMD_FIRST_UNDEF, 32'h0, 32'h0, 2'd0, 4'd0, 16'h0}, 1'b1, 4'd0, 72'h0, 1'b0},
    '{'{CMD_LAST_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 4'd15, 16'hFFFF},
      1'b1, 4'd0, 72'h0, 1'b0},
    '{'{CMD_KEY, 32'h0, 32'h0, 2'd0, 4'd0, 16'h0}, 1'b1, 4'd9, UNLOCK_KEY, 1'b0},
    '{'{CMD_LDS, 32'h0, 32'h0, 2'd0, 4'd0, 16'h0}, 1'b1, 4'd5, 72'h0C, 1'b1},
    '{'{CMD_LDS, 32'hFFFF_FFFF, 32'h0, 2'd0, 4'd0, 16'h0},
      1'b1, 4'd5, 72'hFF_FF_FF_FF_0C, 1'b1},
    '{'{CMD_STS, 32'h1234_5678, 32'h0000_00A5, 2'd1, 4'd7, 16'h00FF},
      1'b0, 4'd0, 72'h0, 1'b0},
    '{'{CMD_STS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0, 4'd0, 16'h0},
      1'b1, 4'd6, 72'hFF_FF_FF_FF_FF_4C, 1'b0},
    '{'{CMD_ST1, 32'h0, 32'h0, 2'd0, 4'd0, 16'h0}, 1'b0, 4'd0, 72'h0, 1'b0},
    '{'{CMD_ST1, 32'h0, 32'h0000_00FF, 2'd3, 4'd0, 16'h0}, 1'b1, 4'd2, 72'hFF_6C, 1'b0},
    '{'{CMD_ST4, 32'h0, 32'h0123_4567, 2'd0, 4'd0, 16'h0}, 1'b0, 4'd0, 72'h0, 1'b0},
    '{'{CMD_ST4, 32'h0, 32'hFFFF_FFFF, 2'd3, 4'd0, 16'h0},
      1'b1, 4'd5, 72'hFF_FF_FF_FF_6F, 1'b0},
    '{'{CMD_STCS, 32'h0, 32'h0, 2'd0, 4'd0, 16'h0}, 1'b1, 4'd2, 72'h00_C0, 1'b0},
    '{'{CMD_STCS, 32'h0, 32'h0000_005A, 2'd2, 4'd15, 16'h0}, 1'b0, 4'd0, 72'h0, 1'b0},
    '{'{CMD_REPEAT1, 32'h0, 32'h0, 2'd0, 4'd0, 16'hFF00}, 1'b1, 4'd2, 72'h00_A0, 1'b0},
    '{'{CMD_REPEAT1, 32'h0, 32'h0, 2'd0, 4'd0, 16'h00FF}, 1'b0, 4'd0, 72'h0, 1'b0},
    '{'{CMD_REPEAT2, 32'h0, 32'h0, 2'd0, 4'd0, 16'h0}, 1'b1, 4'd3, 72'h00_00_A1, 1'b0},
    '{'{CMD_REPEAT2, 32'h0, 32'h0, 2'd0, 4'd0, 16'hFFFF},
      1'b1, 4'd3, 72'hFF_FF_A1, 1'b0},
    '{'{CMD_REPEAT2, 32'h0, 32'h0, 2'd0, 4'd0, 16'h1234}, 1'b0, 4'd0, 72'h0, 1'b0}
  };

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [3:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  link_byte_t pending_bytes [$];
  int         mismatches   = 0;
  int         stall_cycles = 0;
  bit         quiet        = 1'b0;

  pdi_instruction_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_sequence(input logic [7:0] seq [$], input logic reply);
    link_byte_t b;
    for (int i = 0; i < seq.size(); i++) begin
      b.tx_byte        = seq[i];
      b.last_byte      = (i == seq.size() - 1);
      b.reply_expected = b.last_byte & reply;
      pending_bytes.push_back(b);
    end
  endfunction

  function automatic void encode_command(input cmd_item_t c);
    logic [7:0] seq [$];
    logic       reply;
    reply = 1'b0;
    case (c.command)
      CMD_LDS: begin
        seq.push_back(OP_LDS);
        for (int k = 0; k < 4; k++) seq.push_back(c.address[8*k +: 8]);
        reply = 1'b1;
      end
      CMD_STS: begin
        seq.push_back(OP_STS);
        for (int k = 0; k < 4; k++) seq.push_back(c.address[8*k +: 8]);
        seq.push_back(c.data_word[7:0]);
      end
      CMD_LD: begin
        seq.push_back(OP_LD | {4'h0, c.ptr_mode, 2'b00});
        reply = 1'b1;
      end
      CMD_ST1: begin
        seq.push_back(OP_ST1 | {4'h0, c.ptr_mode, 2'b00});
        seq.push_back(c.data_word[7:0]);
      end
      CMD_ST4: begin
        seq.push_back(OP_ST4 | {4'h0, c.ptr_mode, 2'b00});
        for (int k = 0; k < 4; k++) seq.push_back(c.data_word[8*k +: 8]);
      end
      CMD_LDCS: begin
        seq.push_back(OP_LDCS | {4'h0, c.cs_register});
        reply = 1'b1;
      end
      CMD_STCS: begin
        seq.push_back(OP_STCS | {4'h0, c.cs_register});
        seq.push_back(c.data_word[7:0]);
      end
      CMD_REPEAT1: begin
        seq.push_back(OP_REPEAT1);
        seq.push_back(c.repeat_count[7:0]);
      end
      CMD_REPEAT2: begin
        seq.push_back(OP_REPEAT2);
        seq.push_back(c.repeat_count[7:0]);
        seq.push_back(c.repeat_count[15:8]);
      end
      CMD_KEY: begin
        for (int k = 0; k < UNLOCK_KEY_BYTES; k++) seq.push_back(UNLOCK_KEY[8*k +: 8]);
      end
      CMD_RAW: begin
        seq.push_back(c.data_word[7:0]);
      end
      default: begin
        // undefined codes are dropped
      end
    endcase
    push_sequence(seq, reply);
  endfunction

  task automatic push_command(input cmd_item_t c);
    while (!quiet && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.command;
    s_axis_tdata  <= {2'b00, c.repeat_count, c.cs_register, c.ptr_mode,
                      c.data_word, c.address};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    cmd_item_t  c;
    logic [7:0] seq [$];
    int         sent;
    int         next_drain;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      push_command(DIRECTED[i].item);
      if (DIRECTED[i].typed) begin
        seq.delete();
        for (int k = 0; k < DIRECTED[i].n_bytes; k++) seq.push_back(DIRECTED[i].bytes[8*k +: 8]);
        push_sequence(seq, DIRECTED[i].reply);
      end else begin
        encode_command(DIRECTED[i].item);
      end
    end
    wait_for_drain();

    sent = 0;
    next_drain = 100;
    while (sent < RANDOM_COMMANDS) begin
      quiet = (sent >= 120 && sent < 200);
      if (sent == next_drain) begin
        wait_for_drain();
        next_drain += 100;
      end
      if ($urandom_range(15) == 0)
        c.command = 4'($urandom_range(CMD_LAST_UNDEF, CMD_FIRST_UNDEF));
      else
        c.command = 4'($urandom_range(CMD_RAW));
      c.address      = $urandom;
      c.data_word    = $urandom;
      c.ptr_mode     = 2'($urandom_range(3));
      c.cs_register  = 4'($urandom_range(15));
      c.repeat_count = 16'($urandom);
      push_command(c);
      encode_command(c);
      if (c.command <= CMD_RAW) sent++;
    end
    quiet = 1'b0;

    wait_for_drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    link_byte_t exp_b;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected transfer: tx_byte %h last_byte %b reply_expected %b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatches++;
      end else begin
        exp_b = pending_bytes.pop_front();
        if (m_axis_tdata !== exp_b.tx_byte) begin
          $error("tx_byte: expected %h, got %h", exp_b.tx_byte, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== exp_b.last_byte) begin
          $error("last_byte: expected %b, got %b", exp_b.last_byte, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser !== exp_b.reply_expected) begin
          $error("reply_expected: expected %b, got %b", exp_b.reply_expected, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
